/* hw/rtl/ssie_pkg.sv */
// ----------------------------------------------------------------------------
// ssie_pkg
// Shared types and constants for the SSI encoder angle reader: sequencer
// phases, opcodes, register indexes and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package ssie_pkg;

    localparam int FRAME_BITS = 12;
    localparam int BIT_IDX_W  = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

    localparam int RAW_W      = 12;
    localparam int ANGLE_W    = 16;
    localparam int HALF_W     = 16;
    localparam int GAP_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OP_W       = 2;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(100);
    localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(1000000);

    // angle arithmetic: 23040/4095 reduces to 512/91
    localparam int MODULUS      = 4095;
    localparam int FULL_TURN_Q6 = 23040;
    localparam int DIV_SHIFT    = 28;
    localparam int RECIP_W      = 22;
    // ceil(2^28 / 91), exact for every dividend below 2^21
    localparam logic [RECIP_W-1:0] RECIP_91 = RECIP_W'(2949841);
    localparam int SCALED_W     = RAW_W + 9;
    localparam int PROD_W       = SCALED_W + RECIP_W;
    localparam int QUOT_W       = 15;

    typedef enum logic [2:0] {
        PH_START_LOW  = 3'd0,
        PH_START_HIGH = 3'd1,
        PH_BIT_LOW    = 3'd2,
        PH_BIT_HIGH   = 3'd3,
        PH_GAP        = 3'd4
    } phase_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_LOAD    = 2'd1,
        OP_CAPTURE = 2'd2,
        OP_RSVD    = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_BIT  = 2'd0,
        REG_FRAME_GAP = 2'd1
    } reg_index_t;

endpackage

/* hw/rtl/ssie_ifs.sv */
// ----------------------------------------------------------------------------
// ssie channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface ssie_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ssie_pkg::OP_W-1:0]    opcode;
    logic                         data_bit;
    logic [ssie_pkg::RAW_W-1:0]   offset_value;

    modport source (output valid, output opcode, output data_bit, output offset_value,
                    input ready);
    modport sink   (input valid, input opcode, input data_bit, input offset_value,
                    output ready);
endinterface

interface ssie_result_if;
    logic                              valid;
    logic                              ready;
    logic                              ssi_clock;
    logic                              frame_done;
    logic signed [ssie_pkg::ANGLE_W-1:0] angle_q6;
    logic [ssie_pkg::RAW_W-1:0]        raw_angle;

    modport source (output valid, output ssi_clock, output frame_done, output angle_q6,
                    output raw_angle, input ready);
    modport sink   (input valid, input ssi_clock, input frame_done, input angle_q6,
                    input raw_angle, output ready);
endinterface

interface ssie_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ssie_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [ssie_pkg::CFG_DATA_W-1:0]   wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* hw/rtl/ssi_encoder_angle_reader.sv */
// a result passes stage one and then the output register, held until taken
// throughput: one command per cycle unless stalled; state updates on accept and
//   the angle multiply sits between the state registers and the output register
// reset: sequencer at start of the low half, raw and offset zero,
//   half_bit_ticks = 100, frame_gap_ticks = 1000000, no results pending
// ----------------------------------------------------------------------------
// ssi_encoder_angle_reader
// SSI master for a 12-bit absolute encoder, advanced one tick per command,
// with offset calibration and conversion to 1/64 degree.
// ----------------------------------------------------------------------------
module ssi_encoder_angle_reader (
    input  logic            clk,
    input  logic            rst_n,
    ssie_cmd_if.sink        cmd,
    ssie_result_if.source   result,
    ssie_cfg_if.sink        cfg
);
    import ssie_pkg::*;

    // configuration
    logic [HALF_W-1:0]      half_bit_reg;
    logic [GAP_W-1:0]       frame_gap_reg;

    // sequencer state
    phase_t                 phase_reg, phase_next;
    logic [BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    logic [GAP_W-1:0]       tick_reg, tick_next;
    logic [RAW_W-1:0]       shift_reg, shift_next;
    logic [RAW_W-1:0]       raw_reg, raw_next;
    logic [RAW_W-1:0]       offset_reg, offset_next;
    logic                   done_next;

    // pipeline
    logic                   s1_valid_reg;
    logic                   s1_clock_reg;
    logic                   s1_done_reg;
    logic                   out_valid_reg;
    logic                   out_clock_reg;
    logic                   out_done_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;
    logic [RAW_W-1:0]       out_raw_reg;

    logic                   out_free;
    logic                   s1_move;
    logic                   cmd_take;

    logic [GAP_W-1:0]       phase_len;
    logic                   phase_ends;
    logic                   clock_level;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg  <= HALF_RESET;
            frame_gap_reg <= GAP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_HALF_BIT:  half_bit_reg  <= cfg.wdata[HALF_W-1:0];
                REG_FRAME_GAP: frame_gap_reg <= cfg.wdata[GAP_W-1:0];
                default:       ;
            endcase
        end
    end

    // handshake
    assign out_free  = !out_valid_reg || result.ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || out_free;
    assign cmd_take  = cmd.valid && cmd.ready;

    // sequencer
    always_comb
    begin
        if (phase_reg == PH_GAP)
            phase_len = frame_gap_reg;
        else
            phase_len = GAP_W'(half_bit_reg);
        if (phase_len == '0)
            phase_len = GAP_W'(1);
    end

    assign phase_ends  = ({1'b0, tick_reg} + (GAP_W+1)'(1)) >= {1'b0, phase_len};
    assign clock_level = !(phase_reg == PH_START_LOW || phase_reg == PH_BIT_LOW);

    always_comb
    begin
        phase_next   = phase_reg;
        bit_idx_next = bit_idx_reg;
        tick_next    = tick_reg + GAP_W'(1);
        shift_next   = shift_reg;
        raw_next     = raw_reg;
        done_next    = 1'b0;
        if (phase_ends)
        begin
            tick_next = '0;
            unique case (phase_reg)
                PH_START_LOW:
                begin
                    phase_next = PH_START_HIGH;
                end
                PH_START_HIGH:
                begin
                    bit_idx_next = '0;
                    phase_next   = PH_BIT_LOW;
                end
                PH_BIT_LOW:
                begin
                    shift_next = {shift_reg[RAW_W-2:0], cmd.data_bit};
                    phase_next = PH_BIT_HIGH;
                end
                PH_BIT_HIGH:
                begin
                    if (bit_idx_reg == BIT_IDX_W'(FRAME_BITS - 1))
                    begin
                        raw_next     = shift_reg;
                        shift_next   = '0;
                        bit_idx_next = '0;
                        done_next    = 1'b1;
                        phase_next   = PH_GAP;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                        phase_next   = PH_BIT_LOW;
                    end
                end
                default:
                begin
                    shift_next   = '0;
                    bit_idx_next = '0;
                    phase_next   = PH_START_LOW;
                end
            endcase
        end
    end

    // opcode acts after the tick, so a capture sees a freshly stored angle
    always_comb
    begin
        case (opcode_t'(cmd.opcode))
            OP_LOAD:    offset_next = cmd.offset_value;
            OP_CAPTURE: offset_next = raw_next;
            default:    offset_next = offset_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START_LOW;
            bit_idx_reg <= '0;
            tick_reg    <= '0;
            shift_reg   <= '0;
            raw_reg     <= '0;
            offset_reg  <= '0;
        end
        else if (cmd_take)
        begin
            phase_reg   <= phase_next;
            bit_idx_reg <= bit_idx_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
            raw_reg     <= raw_next;
            offset_reg  <= offset_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cmd.ready)
            s1_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_clock_reg <= clock_level;
            s1_done_reg  <= done_next;
        end
    end

    // angle from the state left by the transaction held in stage one
    logic signed [RAW_W:0]  diff;
    logic signed [RAW_W:0]  dmod;
    logic                   d_neg;
    logic [RAW_W-1:0]       d_mag;
    logic [SCALED_W-1:0]    scaled;
    logic [PROD_W-1:0]      prod;
    logic [QUOT_W-1:0]      quot;
    logic signed [ANGLE_W-1:0] angle_next;

    always_comb
    begin
        diff = $signed({1'b0, raw_reg}) - $signed({1'b0, offset_reg});
        if (diff == (RAW_W+1)'(MODULUS) || diff == -(RAW_W+1)'(MODULUS))
            dmod = '0;
        else
            dmod = diff;
        d_neg  = dmod[RAW_W];
        d_mag  = d_neg ? RAW_W'(-dmod) : RAW_W'(dmod);
        scaled = {d_mag, 9'b0};
        prod   = PROD_W'(scaled) * PROD_W'(RECIP_91);
        quot   = prod[DIV_SHIFT +: QUOT_W];
        if (d_neg)
            angle_next = $signed(ANGLE_W'(quot));
        else if (d_mag >= RAW_W'(2048))
            angle_next = $signed(ANGLE_W'(FULL_TURN_Q6) - ANGLE_W'(quot));
        else
            angle_next = -$signed(ANGLE_W'(quot));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_clock_reg <= s1_clock_reg;
            out_done_reg  <= s1_done_reg;
            out_angle_reg <= angle_next;
            out_raw_reg   <= raw_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.ssi_clock  = out_clock_reg;
    assign result.frame_done = out_done_reg;
    assign result.angle_q6   = out_angle_reg;
    assign result.raw_angle  = out_raw_reg;

endmodule
